// ===== sv/bmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants for the button click/hold detector
// Event codes, register indexes, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

	localparam int TIME_BITS   = 32;
	localparam int COUNT_BITS  = 8;
	localparam int MS_BITS     = 16;
	localparam int CFG_IDX_BITS = 2;
	localparam int MAX_PRESSES = 255;

	// The tally register is eight bits wide, so the limit never exceeds 255.
	localparam logic [COUNT_BITS-1:0] TALLY_LIMIT =
		(MAX_PRESSES > 255) ? COUNT_BITS'(255) : COUNT_BITS'(MAX_PRESSES);

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_CLICK = 2'd1,
		EV_HOLD  = 2'd2,
		EV_ERROR = 2'd3
	} event_kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PRESS_LEVEL = 2'd0,
		REG_CLICK_TIME  = 2'd1,
		REG_HOLD_TIME   = 2'd2
	} cfg_index_t;

	localparam logic               RST_PRESS_LEVEL = 1'b1;
	localparam logic [MS_BITS-1:0] RST_CLICK_TIME  = MS_BITS'(300);
	localparam logic [MS_BITS-1:0] RST_HOLD_TIME   = MS_BITS'(1000);

	typedef struct packed {
		logic               press_level;
		logic [MS_BITS-1:0] click_time_ms;
		logic [MS_BITS-1:0] hold_time_ms;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/bmc_if.sv =====
// ----------------------------------------------------------------------------
// bmc_if: channel interfaces of the button click/hold detector
// Poll samples in, events out, and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmc_sample_if;
	logic                         valid;
	logic                         ready;
	logic                         button_level;
	logic [bmc_pkg::TIME_BITS-1:0] now_ms;

	modport source (output valid, output button_level, output now_ms, input ready);
	modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

interface bmc_event_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     event_kind;
	logic [bmc_pkg::COUNT_BITS-1:0] click_count;

	modport source (output valid, output event_kind, output click_count, input ready);
	modport sink   (input valid, input event_kind, input click_count, output ready);
endinterface

interface bmc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bmc_pkg::CFG_IDX_BITS-1:0] index;
	logic [bmc_pkg::MS_BITS-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/button_multi_click_long_press_core.sv =====
// ----------------------------------------------------------------------------
// button_multi_click_long_press_core: multi-click and long-press detector
// Turns timestamped button polls into click-count, long-hold and error events.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one transaction per poll, carrying the button level and a
//            millisecond timestamp that wraps modulo 2^32.
//   result : exactly one transaction per poll, in order: event_kind
//            (none, clicks, long hold, error) and click_count.
//   cfg    : register writes (press level, click time, hold time), always
//            ready; write only while no poll is in flight.
//   A poll is captured in the input register, and its result is loaded into
//   the result register when the decision logic advances.
//   Throughput is one poll per cycle while the receiver takes results: the input
//   register feeds the decision logic, which updates the state and loads the
//   result register in the same cycle.
//   When the receiver stalls, the result register holds its transaction and
//   the input register can still take one more poll; sample.ready drops only
//   when both are full.
//   Reset clears both pipeline stages, restores the register defaults and
//   puts the detector in the released, zero-count state.
// ----------------------------------------------------------------------------
`default_nettype none

module button_multi_click_long_press_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bmc_sample_if.sink  sample,
	bmc_event_if.source result,
	bmc_cfg_if.sink     cfg
);
	import bmc_pkg::*;

	cfg_t                  cfg_cur;
	logic                  valid_s1;
	logic                  level_s1;
	logic [TIME_BITS-1:0]  now_s1;
	logic                  valid_s2;
	event_kind_t           kind_s2;
	logic [COUNT_BITS-1:0] count_s2;
	logic                  advance;
	event_kind_t           kind_d;
	logic [COUNT_BITS-1:0] count_d;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	bmc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	bmc_detect u_detect (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.button_level (level_s1),
		.now_ms       (now_s1),
		.cfg          (cfg_cur),
		.event_kind   (kind_d),
		.click_count  (count_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			level_s1 <= sample.button_level;
			now_s1   <= sample.now_ms;
		end
		if (advance) begin
			kind_s2  <= kind_d;
			count_s2 <= count_d;
		end
	end

	assign result.valid       = valid_s2;
	assign result.event_kind  = kind_s2;
	assign result.click_count = count_s2;

endmodule

`default_nettype wire

// ===== sv/bmc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bmc_cfg_regs: configuration register file
// Holds the press level and the two time thresholds; always ready to write.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_cfg_regs (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bmc_cfg_if.sink     cfg,
	output bmc_pkg::cfg_t cfg_out
);
	import bmc_pkg::*;

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_out   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_level   <= RST_PRESS_LEVEL;
			cfg_q.click_time_ms <= RST_CLICK_TIME;
			cfg_q.hold_time_ms  <= RST_HOLD_TIME;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PRESS_LEVEL: cfg_q.press_level   <= cfg.data[0];
				REG_CLICK_TIME:  cfg_q.click_time_ms <= cfg.data;
				REG_HOLD_TIME:   cfg_q.hold_time_ms  <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/bmc_detect.sv =====
// ----------------------------------------------------------------------------
// bmc_detect: click and hold decision logic with its state registers
// Evaluates one poll per step and, except on an error, updates level, tally, hold flag and time.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_detect (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic                          button_level,
	input  wire logic [bmc_pkg::TIME_BITS-1:0] now_ms,
	input  bmc_pkg::cfg_t                      cfg,
	output bmc_pkg::event_kind_t               event_kind,
	output logic [bmc_pkg::COUNT_BITS-1:0]     click_count
);
	import bmc_pkg::*;

	logic                  prev_level_q, prev_level_d;
	logic [COUNT_BITS-1:0] tally_q, tally_d;
	logic                  holding_q, holding_d;
	logic [TIME_BITS-1:0]  change_time_q, change_time_d;

	logic [TIME_BITS-1:0]  elapsed;
	logic                  was_pressed;
	logic                  is_pressed;
	logic                  bad_state;
	logic                  over_hold;
	logic                  over_click;
	event_kind_t           kind;
	logic [COUNT_BITS-1:0] count;

	assign elapsed     = now_ms - change_time_q;
	assign was_pressed = (prev_level_q == cfg.press_level);
	assign is_pressed  = (button_level == cfg.press_level);
	assign over_hold   = elapsed > TIME_BITS'(cfg.hold_time_ms);
	assign over_click  = elapsed > TIME_BITS'(cfg.click_time_ms);
	// A stale state can appear when the press level is rewritten without a reset.
	assign bad_state   = (!was_pressed && holding_q) ||
		(was_pressed && !holding_q && (tally_q == '0));

	always_comb begin
		prev_level_d  = prev_level_q;
		tally_d       = tally_q;
		holding_d     = holding_q;
		change_time_d = change_time_q;
		kind          = EV_NONE;
		count         = '0;
		if (bad_state) begin
			kind = EV_ERROR;
		end else begin
			prev_level_d = button_level;
			if (was_pressed) begin
				if (is_pressed) begin
					if (holding_q) begin
						kind = EV_HOLD;
					end else if (over_hold) begin
						holding_d = 1'b1;
						tally_d   = '0;
						kind      = EV_HOLD;
					end
				end else begin
					change_time_d = now_ms;
					if (holding_q) begin
						holding_d = 1'b0;
						tally_d   = '0;
					end else if (over_click) begin
						count   = tally_q;
						tally_d = '0;
						kind    = EV_CLICK;
					end
				end
			end else if (is_pressed) begin
				if (tally_q < TALLY_LIMIT) begin
					tally_d = tally_q + COUNT_BITS'(1);
				end
				change_time_d = now_ms;
			end else if (over_hold) begin
				count         = tally_q;
				tally_d       = '0;
				change_time_d = now_ms;
				kind          = EV_CLICK;
			end
		end
		// A report of zero clicks is no event at all.
		if (kind == EV_CLICK && count == '0) begin
			kind = EV_NONE;
		end
	end

	assign event_kind  = kind;
	assign click_count = count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q  <= ~RST_PRESS_LEVEL;
			tally_q       <= '0;
			holding_q     <= 1'b0;
			change_time_q <= '0;
		end else if (step) begin
			prev_level_q  <= prev_level_d;
			tally_q       <= tally_d;
			holding_q     <= holding_d;
			change_time_q <= change_time_d;
		end
	end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for button_multi_click_long_press_core
// A short table of polls and register writes covers strict thresholds, zero
// counts, timestamp wrap, long holds and both inconsistent states. Random
// phases with different press levels and thresholds follow, fed with click
// trains, holds, idle polls and noise. Every event is checked in order
// against the table's own expected event or else a cycle-free detector model.
// ----------------------------------------------------------------------------

module testbench;
	import bmc_pkg::*;

	localparam int RAND_POLLS = 1850;
	localparam int NUM_PHASES = 6;
	localparam int NUM_ROWS   = 32;

	typedef struct packed {
		event_kind_t           kind;
		logic [COUNT_BITS-1:0] count;
	} bmc_event_t;

	typedef struct packed {
		logic                  is_write;
		cfg_index_t            idx;
		logic [MS_BITS-1:0]    data;
		logic                  level;
		logic [TIME_BITS-1:0]  now;
		logic                  typed;
		event_kind_t           kind;
		logic [COUNT_BITS-1:0] count;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	bmc_sample_if smp_ch();
	bmc_event_if  evt_ch();
	bmc_cfg_if    cfg_ch();

	button_multi_click_long_press_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp_ch),
		.result (evt_ch),
		.cfg    (cfg_ch)
	);

	// Shadow registers and detector state.
	logic                  cfg_press = RST_PRESS_LEVEL;
	logic [MS_BITS-1:0]    cfg_click = RST_CLICK_TIME;
	logic [MS_BITS-1:0]    cfg_hold  = RST_HOLD_TIME;
	logic                  last_level = ~RST_PRESS_LEVEL;
	logic [COUNT_BITS-1:0] press_count = '0;
	logic                  in_hold = 1'b0;
	logic [TIME_BITS-1:0]  change_stamp = '0;

	bmc_event_t pending_events [$];
	int mismatch_count = 0;
	int polls_sent = 0;
	int writes_sent = 0;
	int burst_left = 0;
	int kind_seen [4] = '{0, 0, 0, 0};
	int top_count = 0;

	task automatic log_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic bmc_event_t detect_step(input logic level,
	                                           input logic [TIME_BITS-1:0] now);
		logic [TIME_BITS-1:0] elapsed;
		logic was_down;
		logic is_down;
		bmc_event_t ev;
		elapsed = now - change_stamp;
		was_down = (last_level == cfg_press);
		is_down = (level == cfg_press);
		ev.kind = EV_NONE;
		ev.count = '0;
		if ((!was_down && in_hold) || (was_down && !in_hold && press_count == 0)) begin
			ev.kind = EV_ERROR;
			return ev;
		end
		last_level = level;
		if (was_down) begin
			if (is_down) begin
				if (in_hold) begin
					ev.kind = EV_HOLD;
				end else if (elapsed > TIME_BITS'(cfg_hold)) begin
					in_hold = 1'b1;
					press_count = '0;
					ev.kind = EV_HOLD;
				end
			end else begin
				change_stamp = now;
				if (in_hold) begin
					in_hold = 1'b0;
					press_count = '0;
				end else if (elapsed > TIME_BITS'(cfg_click)) begin
					// A report of zero presses comes out as no event.
					ev.kind = (press_count != 0) ? EV_CLICK : EV_NONE;
					ev.count = press_count;
					press_count = '0;
				end
			end
		end else if (is_down) begin
			if (press_count < TALLY_LIMIT)
				press_count++;
			change_stamp = now;
		end else if (elapsed > TIME_BITS'(cfg_hold)) begin
			ev.kind = (press_count != 0) ? EV_CLICK : EV_NONE;
			ev.count = press_count;
			press_count = '0;
			change_stamp = now;
		end
		return ev;
	endfunction

	// Time step that lands on, just past or just short of a threshold, or is zero or random.
	function automatic logic [TIME_BITS-1:0] step_gap(input logic [MS_BITS-1:0] limit);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return TIME_BITS'(limit);
			2: return TIME_BITS'(limit) + 1;
			3: return (limit == 0) ? '0 : TIME_BITS'(limit) - 1;
			4: return $urandom_range(0, 2 * int'(limit) + 2);
			default: return $urandom_range(0, 20);
		endcase
	endfunction

	function automatic vector_t poll(input logic level, input logic [TIME_BITS-1:0] now);
		return '{1'b0, REG_PRESS_LEVEL, '0, level, now, 1'b0, EV_NONE, '0};
	endfunction

	function automatic vector_t poll_is(input logic level, input logic [TIME_BITS-1:0] now,
	                                    input event_kind_t kind,
	                                    input logic [COUNT_BITS-1:0] count);
		return '{1'b0, REG_PRESS_LEVEL, '0, level, now, 1'b1, kind, count};
	endfunction

	function automatic vector_t reg_write(input cfg_index_t idx, input logic [MS_BITS-1:0] data);
		return '{1'b1, idx, data, 1'b0, '0, 1'b0, EV_NONE, '0};
	endfunction

	// Stops the sender and waits until every event has come back.
	task automatic wait_settled();
		smp_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
	endtask

	task automatic feed_poll(input logic level, input logic [TIME_BITS-1:0] now,
	                         input logic typed, input bmc_event_t fixed);
		int gap;
		bmc_event_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 39) == 0) begin
				wait_settled();
			end else if (gap > 0) begin
				smp_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		smp_ch.valid <= 1'b1;
		smp_ch.button_level <= level;
		smp_ch.now_ms <= now;
		do @(posedge clk); while (!smp_ch.ready);
		predicted = detect_step(level, now);
		pending_events.push_back(typed ? fixed : predicted);
		polls_sent++;
	endtask

	// Consecutive writes keep valid high; the last one of a group lowers it.
	task automatic write_reg(input cfg_index_t idx, input logic [MS_BITS-1:0] value,
	                         input logic more);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (!more)
			cfg_ch.valid <= 1'b0;
		case (idx)
			REG_PRESS_LEVEL: cfg_press = value[0];
			REG_CLICK_TIME:  cfg_click = value;
			REG_HOLD_TIME:   cfg_hold = value;
			default: ;
		endcase
		writes_sent++;
	endtask

	always @(posedge clk) begin : check_event
		bmc_event_t want;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			if (!$isunknown(evt_ch.event_kind))
				kind_seen[evt_ch.event_kind]++;
			if (evt_ch.event_kind == EV_CLICK && int'(evt_ch.click_count) > top_count)
				top_count = int'(evt_ch.click_count);
			if (pending_events.size() == 0) begin
				log_mismatch($sformatf("event kind %0d count %0d with nothing expected",
				                       evt_ch.event_kind, evt_ch.click_count));
			end else begin
				want = pending_events.pop_front();
				if (evt_ch.event_kind !== want.kind)
					log_mismatch($sformatf("event_kind %0d, expected %0d",
					                       evt_ch.event_kind, want.kind));
				if (evt_ch.click_count !== want.count)
					log_mismatch($sformatf("click_count %0d, expected %0d",
					                       evt_ch.click_count, want.count));
			end
		end
	end

	// Receiver: stall pattern rotated every cycle, replaced now and then.
	initial begin : event_sink
		logic [15:0] stall_pattern;
		int pattern_age;
		int tap;
		stall_pattern = '1;
		pattern_age = 0;
		tap = 0;
		evt_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(16, 160);
				stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h1;
			end
			pattern_age--;
			tap = (tap + 1) % 16;
			evt_ch.ready <= stall_pattern[tap];
		end
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		vector_t vectors [0:NUM_ROWS-1];
		vector_t row;
		cfg_t phases [0:NUM_PHASES-1];
		logic [TIME_BITS-1:0] clock_ms;
		int directed_polls;
		int target;
		int n;
		int pick;

		smp_ch.valid <= 1'b0;
		smp_ch.button_level <= 1'b0;
		smp_ch.now_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_PRESS_LEVEL;
		cfg_ch.data <= '0;

		vectors = '{
			poll_is(1'b0, 32'd0, EV_NONE, 8'd0),
			poll_is(1'b0, 32'd1001, EV_NONE, 8'd0),
			poll_is(1'b1, 32'd1100, EV_NONE, 8'd0),
			poll_is(1'b0, 32'd1400, EV_NONE, 8'd0),
			poll(1'b1, 32'd1450),
			poll_is(1'b0, 32'd1751, EV_CLICK, 8'd2),
			poll(1'b1, 32'd1800),
			poll(1'b1, 32'd2800),
			poll_is(1'b1, 32'd2801, EV_HOLD, 8'd0),
			poll_is(1'b1, 32'd2802, EV_HOLD, 8'd0),
			poll(1'b0, 32'd5000),
			poll(1'b1, 32'hFFFF_FFFF),
			poll_is(1'b0, 32'h0000_0200, EV_CLICK, 8'd1),
			reg_write(REG_CLICK_TIME, 16'd0),
			reg_write(REG_HOLD_TIME, 16'hFFFF),
			poll(1'b1, 32'h0000_0200),
			poll(1'b0, 32'h0000_0200),
			poll(1'b1, 32'h0000_0201),
			poll_is(1'b0, 32'h0000_0202, EV_CLICK, 8'd2),
			poll(1'b0, 32'h0001_0202),
			reg_write(REG_PRESS_LEVEL, 16'd0),
			poll_is(1'b1, 32'h0001_0300, EV_ERROR, 8'd0),
			reg_write(REG_PRESS_LEVEL, 16'd1),
			poll(1'b0, 32'h0001_0301),
			reg_write(REG_HOLD_TIME, 16'd0),
			poll(1'b1, 32'h0001_0400),
			poll_is(1'b1, 32'h0001_0401, EV_HOLD, 8'd0),
			reg_write(REG_PRESS_LEVEL, 16'd0),
			poll_is(1'b0, 32'h0001_0402, EV_ERROR, 8'd0),
			reg_write(REG_PRESS_LEVEL, 16'd1),
			poll_is(1'b1, 32'h0001_0403, EV_HOLD, 8'd0),
			poll(1'b0, 32'h0001_0404)
		};
		phases = '{
			'{1'b1, 16'd300, 16'd1000},
			'{1'b0, 16'd0, 16'd0},
			'{1'b1, 16'hFFFF, 16'hFFFF},
			'{1'b0, 16'd25, 16'd200},
			'{1'b1, 16'd0, 16'd0},
			'{1'b0, 16'd1000, 16'd300}
		};
		phases[4].click_time_ms = 16'($urandom);
		phases[4].hold_time_ms = 16'($urandom);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = vectors[i];
			if (row.is_write) begin
				if (i == 0 || !vectors[i-1].is_write)
					wait_settled();
				write_reg(row.idx, row.data, (i + 1 < NUM_ROWS) && vectors[i+1].is_write);
			end else begin
				feed_poll(row.level, row.now, row.typed, '{row.kind, row.count});
			end
		end
		directed_polls = polls_sent;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_settled();
			// Flipping the press level from a released, empty state would leave
			// the detector stuck in error, so first leave it pressed with a count.
			if (phases[ph].press_level != cfg_press) begin
				if (last_level == cfg_press && in_hold)
					feed_poll(~cfg_press, change_stamp, 1'b0, '0);
				if (last_level != cfg_press)
					feed_poll(cfg_press, change_stamp, 1'b0, '0);
				wait_settled();
			end
			write_reg(REG_PRESS_LEVEL, MS_BITS'(phases[ph].press_level), 1'b1);
			write_reg(REG_CLICK_TIME, phases[ph].click_time_ms, 1'b1);
			write_reg(REG_HOLD_TIME, phases[ph].hold_time_ms, 1'b0);

			clock_ms = (ph == 0) ? change_stamp : $urandom;
			target = directed_polls + (ph + 1) * RAND_POLLS / NUM_PHASES;

			if (ph == 0) begin
				// Long click train to drive the press count into saturation.
				repeat (260) begin
					clock_ms += $urandom_range(0, cfg_hold);
					feed_poll(cfg_press, clock_ms, 1'b0, '0);
					clock_ms += $urandom_range(0, cfg_click);
					feed_poll(~cfg_press, clock_ms, 1'b0, '0);
				end
				clock_ms += TIME_BITS'(cfg_hold) + 1;
				feed_poll(~cfg_press, clock_ms, 1'b0, '0);
			end

			while (polls_sent < target) begin
				pick = $urandom_range(0, 9);
				n = $urandom_range(1, 5);
				if (pick < 5) begin
					repeat (n) begin
						clock_ms += $urandom_range(0, 1) ? step_gap(cfg_hold)
						                                 : $urandom_range(0, cfg_hold);
						feed_poll(cfg_press, clock_ms, 1'b0, '0);
						clock_ms += step_gap(cfg_click);
						feed_poll(~cfg_press, clock_ms, 1'b0, '0);
					end
				end else if (pick < 7) begin
					clock_ms += step_gap(cfg_hold);
					feed_poll(cfg_press, clock_ms, 1'b0, '0);
					repeat (n) begin
						clock_ms += step_gap(cfg_hold);
						feed_poll(cfg_press, clock_ms, 1'b0, '0);
					end
					clock_ms += step_gap(cfg_click);
					feed_poll(~cfg_press, clock_ms, 1'b0, '0);
				end else if (pick < 9) begin
					repeat (n) begin
						clock_ms += step_gap(cfg_hold);
						feed_poll(~cfg_press, clock_ms, 1'b0, '0);
					end
				end else begin
					repeat (n) begin
						clock_ms = $urandom;
						feed_poll(1'($urandom_range(0, 1)), clock_ms, 1'b0, '0);
					end
				end
			end
		end

		wait_settled();
		repeat (8) @(posedge clk);

		$display("Ran %0d polls (%0d from the table) and %0d register writes over %0d phases.",
		         polls_sent, directed_polls, writes_sent, NUM_PHASES);
		$display("Events: %0d none, %0d clicks (up to %0d presses), %0d holds, %0d errors.",
		         kind_seen[0], kind_seen[1], top_count, kind_seen[2], kind_seen[3]);
		if (mismatch_count == 0 && pending_events.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
